// File: design/tbc_pkg.sv
// Shared constants, codes and types for the triangle barycentric block.
`timescale 1ns / 1ps
package tbc_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IN_W           = 16;
  localparam int OUT_W          = 24;
  localparam int TOL_W          = 32;
  localparam int CAP_W          = 21;
  localparam int INT_CAP        = 1 << 20;
  localparam int OUT_MAX        = 8388607;
  localparam int OUT_MIN        = -8388608;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FLAT = 2'd1;
  localparam logic [1:0] ST_ZDET = 2'd2;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] drop;
    logic       neg_a;
    logic       neg_b;
  } tbc_meta_t;
endpackage

// File: design/tbc_div.sv
// Pipelined restoring divider producing one quotient bit per register stage.
`timescale 1ns / 1ps
module tbc_div #(
  parameter int NW = 35,
  parameter int F  = 16
) (
  input  logic              clk,
  input  logic [NW-1:0]     num,
  input  logic [NW-1:0]     den,
  output logic [NW+F-1:0]   quo
);
  localparam int W = NW + F;

  logic [NW-1:0] rem_r [W];
  logic [W-1:0]  qd_r  [W];
  logic [NW-1:0] d_r   [W];

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [NW-1:0] rin;
    logic [NW-1:0] din;
    logic [W-1:0]  qin;
    logic [NW:0]   t;
    logic          ge;
    if (k == 0) begin : g_first
      assign rin = '0;
      assign qin = {num, {F{1'b0}}};
      assign din = den;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign qin = qd_r[k-1];
      assign din = d_r[k-1];
    end
    assign t  = {rin, qin[W-1]};
    assign ge = (t >= {1'b0, din});
    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? NW'(t - {1'b0, din}) : NW'(t);
      qd_r[k]  <= {qin[W-2:0], ge};
      d_r[k]   <= din;
    end
  end

  assign quo = qd_r[W-1];
endmodule

// File: design/triangle_barycentric_3d_top.sv
// Top level of the triangle barycentric weight pipeline with its APB register.
`timescale 1ns / 1ps
// Usage: a caller presents a triangle A, B, C and a query point on the in_
// ports and raises start. An item is transferred at every clock edge where
// start is high and busy is low; busy is always low, so a new item may be
// transferred in every cycle and many items are in flight at once.
// Each item yields exactly one result, shown for one cycle with out_valid
// high: three Q-format weights, the dropped axis and a status code. An
// item passes through nine front stages (cross product, axis choice,
// edge functions), then the divider, which resolves one quotient bit per
// stage, and then two back stages (clamp, third weight and saturation).
// Throughput is one item per cycle.
// The register zero_tolerance sits at byte address 0 of the APB port; write
// it only while no item is in flight. Synchronous reset clears the register
// and all valid bits; results already in flight are dropped. The receiver
// cannot stall: every result must be taken in the cycle it is shown.
module triangle_barycentric_3d_top
  import tbc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_a_x,
  input  logic signed [IN_W-1:0]  in_a_y,
  input  logic signed [IN_W-1:0]  in_a_z,
  input  logic signed [IN_W-1:0]  in_b_x,
  input  logic signed [IN_W-1:0]  in_b_y,
  input  logic signed [IN_W-1:0]  in_b_z,
  input  logic signed [IN_W-1:0]  in_c_x,
  input  logic signed [IN_W-1:0]  in_c_y,
  input  logic signed [IN_W-1:0]  in_c_z,
  input  logic signed [IN_W-1:0]  in_query_x,
  input  logic signed [IN_W-1:0]  in_query_y,
  input  logic signed [IN_W-1:0]  in_query_z,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_weight_a,
  output logic signed [OUT_W-1:0] out_weight_b,
  output logic signed [OUT_W-1:0] out_weight_c,
  output logic [1:0]              out_drop_axis,
  output logic [1:0]              out_status,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [TOL_W-1:0]        pwdata,
  output logic [TOL_W-1:0]        prdata,
  output logic                    pready
);
  localparam int CW   = COORD_BITS;
  localparam int XW   = (CW > IN_W) ? CW : IN_W;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * CW + 2;
  localparam int SW   = 2 * CW + 3;
  localparam int CMPW = (SW > TOL_W) ? SW : TOL_W;
  localparam int W    = SW + FRAC_BITS;
  localparam int EW   = (SW > CAP_W) ? SW : CAP_W;
  localparam int QW   = CAP_W + 1 + FRAC_BITS;
  localparam int RW   = QW + 2;
  localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);
  localparam logic signed [RW-1:0] ONE_FX = RW'(1) << FRAC_BITS;

  function automatic logic signed [CW-1:0] sx(input logic [IN_W-1:0] p);
    logic [XW-1:0] e;
    e = XW'(p);
    return e[CW-1:0];
  endfunction

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] c;
    c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
    return c[OUT_W-1:0];
  endfunction

  // Configuration register.
  logic [TOL_W-1:0] tol_r;
  logic             cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == 3'd0);
  assign prdata = (paddr == 3'd0) ? tol_r : '0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr) begin
      tol_r <= pwdata;
    end
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // Stage 1: capture coordinates in the working width.
  logic signed [CW-1:0] cin [12];
  assign cin[0]  = sx(in_a_x);
  assign cin[1]  = sx(in_a_y);
  assign cin[2]  = sx(in_a_z);
  assign cin[3]  = sx(in_b_x);
  assign cin[4]  = sx(in_b_y);
  assign cin[5]  = sx(in_b_z);
  assign cin[6]  = sx(in_c_x);
  assign cin[7]  = sx(in_c_y);
  assign cin[8]  = sx(in_c_z);
  assign cin[9]  = sx(in_query_x);
  assign cin[10] = sx(in_query_y);
  assign cin[11] = sx(in_query_z);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r;
  logic signed [CW-1:0] c1_r [12];
  logic signed [CW-1:0] c2_r [12];
  logic signed [CW-1:0] c3_r [12];
  logic signed [CW-1:0] c4_r [12];
  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] e2_r [3];
  logic signed [PW-1:0] pr_r [6];
  logic signed [SW-1:0] n_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0; v9_r <= 1'b0;
    end else begin
      v1_r <= accept; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r; v9_r <= v8_r;
    end
  end

  // Stages 1 to 4: edges, cross-product terms, normal.
  always_ff @(posedge clk) begin
    c1_r <= cin;
    c2_r <= c1_r;
    c3_r <= c2_r;
    c4_r <= c3_r;
    for (int j = 0; j < 3; j++) begin
      e1_r[j] <= DW'(c1_r[3+j]) - DW'(c1_r[j]);
      e2_r[j] <= DW'(c1_r[6+j]) - DW'(c1_r[j]);
    end
    pr_r[0] <= PW'(e1_r[1]) * PW'(e2_r[2]);
    pr_r[1] <= PW'(e1_r[2]) * PW'(e2_r[1]);
    pr_r[2] <= PW'(e1_r[2]) * PW'(e2_r[0]);
    pr_r[3] <= PW'(e1_r[0]) * PW'(e2_r[2]);
    pr_r[4] <= PW'(e1_r[0]) * PW'(e2_r[1]);
    pr_r[5] <= PW'(e1_r[1]) * PW'(e2_r[0]);
    for (int j = 0; j < 3; j++) begin
      n_r[j] <= SW'(pr_r[2*j]) - SW'(pr_r[2*j+1]);
    end
  end

  // Stage 5: flat test, dominant axis, projection onto the kept plane.
  logic [SW-1:0]        nm [3];
  logic                 flat;
  logic [1:0]           drop_sel;
  logic [1:0]           iu, iv;
  logic signed [CW-1:0] uv [8];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nm[j] = mag(n_r[j]);
    end
    flat = (CMPW'(nm[0]) <= CMPW'(tol_r)) && (CMPW'(nm[1]) <= CMPW'(tol_r)) &&
           (CMPW'(nm[2]) <= CMPW'(tol_r));
    drop_sel = AX_X;
    if (nm[1] > nm[0]) begin
      drop_sel = AX_Y;
    end
    if (nm[2] > ((drop_sel == AX_Y) ? nm[1] : nm[0])) begin
      drop_sel = AX_Z;
    end
    iu = (drop_sel == AX_X) ? AX_Y : AX_X;
    iv = (drop_sel == AX_Z) ? AX_Y : AX_Z;
    for (int p = 0; p < 4; p++) begin
      uv[2*p]   = c4_r[4'(p*3) + {2'b00, iu}];
      uv[2*p+1] = c4_r[4'(p*3) + {2'b00, iv}];
    end
  end

  logic                 flat5_r, flat6_r, flat7_r, flat8_r;
  logic [1:0]           drop5_r, drop6_r, drop7_r, drop8_r;
  logic signed [CW-1:0] uv5_r [8];
  logic signed [DW-1:0] d6_r  [8];
  logic signed [PW-1:0] m7_r  [6];
  logic signed [SW-1:0] det8_r, ea8_r, eb8_r;

  // Stages 5 to 8: coordinate differences, products, determinant and edges.
  // uv order: ua va ub vb uc vc uq vq.
  always_ff @(posedge clk) begin
    flat5_r <= flat;
    drop5_r <= flat ? AX_X : drop_sel;
    uv5_r   <= uv;
    flat6_r <= flat5_r;
    drop6_r <= drop5_r;
    d6_r[0] <= DW'(uv5_r[0]) - DW'(uv5_r[4]);
    d6_r[1] <= DW'(uv5_r[3]) - DW'(uv5_r[5]);
    d6_r[2] <= DW'(uv5_r[2]) - DW'(uv5_r[4]);
    d6_r[3] <= DW'(uv5_r[1]) - DW'(uv5_r[5]);
    d6_r[4] <= DW'(uv5_r[6]) - DW'(uv5_r[4]);
    d6_r[5] <= DW'(uv5_r[7]) - DW'(uv5_r[5]);
    d6_r[6] <= DW'(uv5_r[4]) - DW'(uv5_r[2]);
    d6_r[7] <= DW'(uv5_r[5]) - DW'(uv5_r[1]);
    flat7_r <= flat6_r;
    drop7_r <= drop6_r;
    m7_r[0] <= PW'(d6_r[0]) * PW'(d6_r[1]);
    m7_r[1] <= PW'(d6_r[2]) * PW'(d6_r[3]);
    m7_r[2] <= PW'(d6_r[1]) * PW'(d6_r[4]);
    m7_r[3] <= PW'(d6_r[6]) * PW'(d6_r[5]);
    m7_r[4] <= PW'(d6_r[7]) * PW'(d6_r[4]);
    m7_r[5] <= PW'(d6_r[0]) * PW'(d6_r[5]);
    flat8_r <= flat7_r;
    drop8_r <= drop7_r;
    det8_r  <= SW'(m7_r[0]) - SW'(m7_r[1]);
    ea8_r   <= SW'(m7_r[2]) + SW'(m7_r[3]);
    eb8_r   <= SW'(m7_r[4]) + SW'(m7_r[5]);
  end

  // Stage 9: status and operand magnitudes for the dividers.
  tbc_meta_t     meta9_r;
  logic [SW-1:0] ma9_r, mb9_r, md9_r;
  logic [SW-1:0] detm;
  assign detm = mag(det8_r);
  always_ff @(posedge clk) begin
    meta9_r.status <= flat8_r ? ST_FLAT :
                      ((CMPW'(detm) <= CMPW'(tol_r)) ? ST_ZDET : ST_OK);
    meta9_r.drop   <= drop8_r;
    meta9_r.neg_a  <= ea8_r[SW-1] ^ det8_r[SW-1];
    meta9_r.neg_b  <= eb8_r[SW-1] ^ det8_r[SW-1];
    ma9_r <= mag(ea8_r);
    mb9_r <= mag(eb8_r);
    md9_r <= detm;
  end

  logic [W-1:0] qa, qb;
  tbc_div #(.NW(SW), .F(FRAC_BITS)) u_div_a (
    .clk(clk), .num(ma9_r), .den(md9_r), .quo(qa)
  );
  tbc_div #(.NW(SW), .F(FRAC_BITS)) u_div_b (
    .clk(clk), .num(mb9_r), .den(md9_r), .quo(qb)
  );

  // Side data travels alongside the divider stages.
  tbc_meta_t meta_r [W];
  logic      vd_r   [W];
  always_ff @(posedge clk) begin
    meta_r[0] <= meta9_r;
    for (int k = 1; k < W; k++) begin
      meta_r[k] <= meta_r[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < W; k++) begin
        vd_r[k] <= 1'b0;
      end
    end else begin
      vd_r[0] <= v9_r;
      for (int k = 1; k < W; k++) begin
        vd_r[k] <= vd_r[k-1];
      end
    end
  end

  // Clamp the integer part, append the fraction and apply the sign.
  function automatic logic signed [QW-1:0] fix_q(input logic [W-1:0] q,
                                                 input logic neg);
    logic [EW-1:0]        qi;
    logic [CAP_W-1:0]     ci;
    logic [QW-1:0]        qm;
    qi = EW'(q[W-1:FRAC_BITS]);
    ci = (qi > EW'(INT_CAP)) ? CAP_W'(INT_CAP) : qi[CAP_W-1:0];
    qm = QW'({ci, q[FRAC_BITS-1:0]});
    return neg ? QW'(-qm) : QW'(qm);
  endfunction

  logic                 vq_r;
  tbc_meta_t            metaq_r;
  logic signed [QW-1:0] wa_r, wb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
    end else begin
      vq_r <= vd_r[W-1];
    end
  end
  always_ff @(posedge clk) begin
    metaq_r <= meta_r[W-1];
    wa_r    <= fix_q(qa, meta_r[W-1].neg_a);
    wb_r    <= fix_q(qb, meta_r[W-1].neg_b);
  end

  // Output stage: third weight, saturation, zero weights on error.
  logic signed [RW-1:0] wc;
  logic                 ok;
  assign wc = ONE_FX - RW'(wa_r) - RW'(wb_r);
  assign ok = (metaq_r.status == ST_OK);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vq_r;
    end
  end
  always_ff @(posedge clk) begin
    out_weight_a  <= ok ? sat(RW'(wa_r)) : '0;
    out_weight_b  <= ok ? sat(RW'(wb_r)) : '0;
    out_weight_c  <= ok ? sat(wc) : '0;
    out_drop_axis <= metaq_r.drop;
    out_status    <= metaq_r.status;
  end
endmodule

// File: design/tbc_checker.sv
// Port-level checker for the triangle barycentric block and its bind.
`timescale 1ns / 1ps
module tbc_checker
  import tbc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    busy,
  input logic                    out_valid,
  input logic signed [OUT_W-1:0] out_weight_a,
  input logic signed [OUT_W-1:0] out_weight_b,
  input logic signed [OUT_W-1:0] out_weight_c,
  input logic [1:0]              out_drop_axis,
  input logic [1:0]              out_status
);
  // The pipeline never refuses a transfer.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // The cycle after reset shows no result.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result right after reset");

  // A failed item carries all-zero weights.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_status != ST_OK |->
      out_weight_a == '0 && out_weight_b == '0 && out_weight_c == '0)
    else $error("nonzero weights on error");

  // A flat triangle reports the x axis, and no axis code beyond z appears.
  a_axis: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_drop_axis != 2'd3) &&
      (out_status != ST_FLAT || out_drop_axis == AX_X))
    else $error("bad drop axis");
endmodule

bind triangle_barycentric_3d_top tbc_checker u_tbc_checker (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_weight_a(out_weight_a), .out_weight_b(out_weight_b),
  .out_weight_c(out_weight_c), .out_drop_axis(out_drop_axis),
  .out_status(out_status)
);
